// ===== rtl/hrfw_pkg.sv =====
// Shared types, character codes and helpers for the hex record flash writer.
package hrfw_pkg;

  localparam int POS_W       = 10;
  localparam int IDX_W       = 7;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [7:0] CHAR_COLON  = 8'h3A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_F   = 8'h46;
  localparam logic [7:0] HEX_A_BIAS  = 8'd55;

  // record type codes, taken as the raw character at position 8
  localparam logic [7:0] REC_TYPE_DATA = 8'h30;
  localparam logic [7:0] REC_TYPE_ELA  = 8'h34;

  // halfword write command handed from the parser to the write stage
  typedef struct packed {
    logic [31:0]      base;
    logic [15:0]      offset;
    logic [IDX_W-1:0] index;
    logic [15:0]      data;
    logic             last;
  } hrfw_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hrfw_qstat_t;

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = c - CHAR_ZERO;
    end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
      v = c - HEX_A_BIAS;
    end
    return v[3:0];
  endfunction

endpackage

// ===== rtl/hrfw_front.sv =====
// Record parser: tracks character position, decodes header fields, builds write commands.
module hrfw_front import hrfw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] character,
  output logic       cmd_valid,
  output hrfw_cmd_t  cmd
);

  logic [31:0]      base_r, base_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [15:0]      off_r, off_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [15:0]      acc_r, acc_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             in_rec_r, in_rec_nxt;

  logic [3:0]       nib;
  logic [IDX_W-1:0] count;

  assign nib   = hex_nibble(character);
  assign count = len_r[7:1];

  always_comb begin
    base_nxt   = base_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    off_nxt    = off_r;
    type_nxt   = type_r;
    acc_nxt    = acc_r;
    idx_nxt    = idx_r;
    in_rec_nxt = in_rec_r;
    cmd_valid  = 1'b0;
    cmd.base   = base_r;
    cmd.offset = off_r;
    cmd.index  = idx_r;
    cmd.data   = 16'd0;
    cmd.last   = 1'b0;
    if (fire) begin
      if (character == CHAR_COLON) begin
        in_rec_nxt = 1'b1;
        pos_nxt    = '0;
        len_nxt    = '0;
        off_nxt    = '0;
        type_nxt   = '0;
        acc_nxt    = '0;
        idx_nxt    = '0;
      end else if (in_rec_r) begin
        if (pos_r != POS_MAX) pos_nxt = pos_r + POS_W'(1);
        if (pos_nxt == POS_W'(1) || pos_nxt == POS_W'(2)) begin
          len_nxt = {len_r[3:0], nib};
        end else if (pos_nxt >= POS_W'(3) && pos_nxt <= POS_W'(6)) begin
          off_nxt = {off_r[11:0], nib};
        end else if (pos_nxt == POS_W'(8)) begin
          type_nxt = character;
        end else if (pos_nxt >= POS_W'(9)) begin
          acc_nxt = {acc_r[11:0], nib};
          if (type_r == REC_TYPE_ELA) begin
            if (pos_nxt == POS_W'(12)) base_nxt = {acc_nxt, 16'd0};
          end else if (type_r == REC_TYPE_DATA && pos_nxt >= POS_W'(12) &&
                       pos_nxt[1:0] == 2'b00 && idx_r < count) begin
            // every fourth data character closes a halfword
            cmd_valid = 1'b1;
            cmd.data  = {acc_nxt[7:0], acc_nxt[15:8]};
            cmd.last  = (idx_r + IDX_W'(1)) == count;
            idx_nxt   = idx_r + IDX_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      pos_r    <= '0;
      len_r    <= '0;
      off_r    <= '0;
      type_r   <= '0;
      acc_r    <= '0;
      idx_r    <= '0;
      in_rec_r <= 1'b0;
    end else begin
      base_r   <= base_nxt;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      off_r    <= off_nxt;
      type_r   <= type_nxt;
      acc_r    <= acc_nxt;
      idx_r    <= idx_nxt;
      in_rec_r <= in_rec_nxt;
    end
  end

endmodule

// ===== rtl/hrfw_queue.sv =====
// Small command FIFO between the parser and the write stage.
module hrfw_queue import hrfw_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  hrfw_cmd_t   wr_data,
  input  logic        rd_en,
  output hrfw_cmd_t   rd_data,
  output hrfw_qstat_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hrfw_cmd_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign status.full  = count_r == CNT_W'(DEPTH);
  assign status.empty = count_r == '0;
  assign rd_data      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/hrfw_back.sv =====
// Write stage: forms the flash address and holds the result item in the output register.
module hrfw_back import hrfw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  hrfw_cmd_t   cmd,
  output logic        cmd_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_write_address,
  output logic [15:0] out_write_data,
  output logic        out_last_in_record
);

  logic        valid_r, valid_nxt;
  logic [31:0] addr_r;
  logic [15:0] data_r;
  logic        last_r;
  logic [31:0] addr_nxt;

  assign cmd_pop   = cmd_valid && (!valid_r || out_ready);
  assign valid_nxt = cmd_pop || (valid_r && !out_ready);
  // wraps modulo 2^32
  assign addr_nxt  = cmd.base + {16'd0, cmd.offset} + {{(31 - IDX_W){1'b0}}, cmd.index, 1'b0};

  assign out_valid          = valid_r;
  assign out_write_address  = addr_r;
  assign out_write_data     = data_r;
  assign out_last_in_record = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      addr_r <= addr_nxt;
      data_r <= cmd.data;
      last_r <= cmd.last;
    end
  end

endmodule

// ===== rtl/hex_record_flash_writer.sv =====
// Intel HEX record stream to halfword flash writes.
// A write item passes through the command queue and then the output register.
// Throughput: one character per cycle; the parser stalls only when the command queue is full.
// Queue depth QUEUE_DEPTH_P absorbs output stalls without a bubble.
// Reset (rst_n low, synchronous) clears the base address, record state, queue and output valid.
module hex_record_flash_writer import hrfw_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_character,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_write_address,
  output logic [15:0] out_write_data,
  output logic        out_last_in_record
);

  logic        fire;
  logic        cmd_valid;
  hrfw_cmd_t   cmd;
  hrfw_cmd_t   q_data;
  hrfw_qstat_t q_stat;
  logic        q_pop;

  assign in_ready = !q_stat.full;
  assign fire     = in_valid && in_ready;

  hrfw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .character (in_character),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  hrfw_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_valid),
    .wr_data (cmd),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .status  (q_stat)
  );

  hrfw_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (!q_stat.empty),
    .cmd                (q_data),
    .cmd_pop            (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_write_address  (out_write_address),
    .out_write_data     (out_write_data),
    .out_last_in_record (out_last_in_record)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid |-> !q_stat.full)
    else $error("command pushed into a full queue");

  a_full_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue flags full and empty together");

  a_out_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!q_stat.empty))
    else $error("result item appeared without a queued command");

  a_push_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && !q_pop) |=> !q_stat.empty)
    else $error("pushed command lost");

endmodule

// ===== verif/hex_record_flash_writer_checker.sv =====
`timescale 1ns / 100ps
// Checker for the hex record flash writer: decodes accepted characters and compares each write.
module hex_record_flash_writer_checker import hrfw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_character,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_write_address,
  input  logic [15:0] out_write_data,
  input  logic        out_last_in_record,
  output int          mismatches,
  output int          writes_pending
);

  typedef struct packed {
    logic [31:0] address;
    logic [15:0] data;
    logic        last;
  } flash_write_t;

  flash_write_t expected_writes[$];
  int fail_count = 0;
  int pending_count = 0;

  // decoder state, mirrors what the block keeps between characters
  logic [31:0]      base_addr;
  logic [POS_W-1:0] rec_pos;
  logic [7:0]       rec_len;
  logic [15:0]      rec_offset;
  logic [7:0]       rec_type;
  logic [15:0]      nibble_hist;
  logic [IDX_W-1:0] halfword_cnt;
  logic             rec_open;

  assign mismatches     = fail_count;
  assign writes_pending = pending_count;

  function automatic logic [3:0] char_nibble(input logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return c[3:0];
    if (c >= CHAR_UP_A && c <= CHAR_UP_F) return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  // Advances the decoder by one character; returns 1 when a write follows from it.
  function automatic bit decode_char(input logic [7:0] c, output flash_write_t wr);
    logic [3:0]       nib;
    logic [IDX_W-1:0] groups;
    nib = char_nibble(c);
    wr  = '0;
    if (c == CHAR_COLON) begin
      rec_open     = 1'b1;
      rec_pos      = '0;
      rec_len      = '0;
      rec_offset   = '0;
      rec_type     = '0;
      nibble_hist  = '0;
      halfword_cnt = '0;
      return 1'b0;
    end
    if (!rec_open) return 1'b0;
    if (rec_pos != POS_MAX) rec_pos = rec_pos + 1'b1;
    if (rec_pos == 1 || rec_pos == 2) begin
      rec_len = {rec_len[3:0], nib};
      return 1'b0;
    end
    if (rec_pos >= 3 && rec_pos <= 6) begin
      rec_offset = {rec_offset[11:0], nib};
      return 1'b0;
    end
    if (rec_pos == 8) begin
      rec_type = c;
      return 1'b0;
    end
    if (rec_pos < 9) return 1'b0;

    nibble_hist = {nibble_hist[11:0], nib};
    if (rec_type == REC_TYPE_ELA) begin
      if (rec_pos == 12) base_addr = {nibble_hist, 16'h0000};
      return 1'b0;
    end
    // data groups close at positions 12, 16, 20, ...
    if (rec_type == REC_TYPE_DATA && rec_pos >= 12 && rec_pos[1:0] == 2'b00) begin
      groups = rec_len[7:1];
      if (halfword_cnt < groups) begin
        wr.address   = base_addr + 32'(rec_offset) + 32'({halfword_cnt, 1'b0});
        wr.data      = {nibble_hist[7:0], nibble_hist[15:8]};
        wr.last      = (halfword_cnt == groups - 1'b1);
        halfword_cnt = halfword_cnt + 1'b1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    flash_write_t exp_wr;
    flash_write_t new_wr;
    if (!rst_n) begin
      base_addr    = '0;
      rec_pos      = '0;
      rec_len      = '0;
      rec_offset   = '0;
      rec_type     = '0;
      nibble_hist  = '0;
      halfword_cnt = '0;
      rec_open     = 1'b0;
      expected_writes.delete();
    end else begin
      // a write leaves only after passing the queue and the output register, so pop before push
      if (out_valid && out_ready) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: unexpected write: address %h data %h last %b", $time,
                   out_write_address, out_write_data, out_last_in_record);
          fail_count++;
        end else begin
          exp_wr = expected_writes.pop_front();
          if (out_write_address !== exp_wr.address) begin
            $display("%0t: write address: expected %h, actual %h", $time,
                     exp_wr.address, out_write_address);
            fail_count++;
          end
          if (out_write_data !== exp_wr.data) begin
            $display("%0t: write data: expected %h, actual %h", $time,
                     exp_wr.data, out_write_data);
            fail_count++;
          end
          if (out_last_in_record !== exp_wr.last) begin
            $display("%0t: last in record: expected %b, actual %b", $time,
                     exp_wr.last, out_last_in_record);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (decode_char(in_character, new_wr)) expected_writes.push_back(new_wr);
      end
    end
    pending_count = expected_writes.size();
  end

endmodule

// ===== verif/hex_record_flash_writer_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the hex record flash writer: record stimulus, flow control and verdict.
module hex_record_flash_writer_tb;
  import hrfw_pkg::*;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam int RANDOM_CHARS = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_character = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_write_address;
  logic [15:0] out_write_data;
  logic        out_last_in_record;

  int mismatches;
  int writes_pending;
  int chars_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  logic hold_off_req = 1'b0;

  always #5 clk = ~clk;

  hex_record_flash_writer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_character       (in_character),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_write_address  (out_write_address),
    .out_write_data     (out_write_data),
    .out_last_in_record (out_last_in_record)
  );

  hex_record_flash_writer_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_character       (in_character),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_write_address  (out_write_address),
    .out_write_data     (out_write_data),
    .out_last_in_record (out_last_in_record),
    .mismatches         (mismatches),
    .writes_pending     (writes_pending)
  );

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    return (n < 4'd10) ? CHAR_ZERO + n : CHAR_UP_A + (n - 4'd10);
  endfunction

  // Offers one item and returns at the edge that accepts it; idles between bursts.
  task automatic send_char(input logic [7:0] c);
    in_valid     <= 1'b1;
    in_character <= c;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
    end
  endtask

  task automatic send_hex_byte(input logic [7:0] b);
    send_char(hex_digit(b[7:4]));
    send_char(hex_digit(b[3:0]));
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_record(input logic [7:0] len, input logic [15:0] ofs,
                             input logic [7:0] type_char, input int n_payload, input bit garble);
    send_char(CHAR_COLON);
    send_hex_byte(len);
    send_hex_byte(ofs[15:8]);
    send_hex_byte(ofs[7:0]);
    send_char(hex_digit(4'($urandom_range(0, 15))));
    send_char(type_char);
    for (int i = 0; i < n_payload; i++) begin
      if (garble && $urandom_range(0, 4) == 0) send_char(8'($urandom_range(0, 255)));
      else send_char(hex_digit(4'($urandom_range(0, 15))));
    end
    send_hex_byte(8'($urandom));  // checksum, not checked by the block
    if ($urandom_range(0, 1) == 1) begin
      send_char(CHAR_CR);
      send_char(CHAR_LF);
    end
  endtask

  task automatic wait_for_writes();
    do @(negedge clk); while (writes_pending != 0);
    @(posedge clk);
  endtask

  // Receiver: switches between random stall patterns, long hold-off on request.
  initial begin : receiver
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req <= 1'b0;
        out_ready    <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (cyc % 48 == 0) mode = $urandom_range(0, 3);
        cyc++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((cyc % 5) < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("** hex_record_flash_writer: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    bit         held;
    bit         drained;
    bit         long_done;
    int         pick;
    int         len;
    int         n_payload;
    logic [7:0] type_char;
    held      = 1'b0;
    drained   = 1'b0;
    long_done = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // junk before the first colon is dropped
    send_string("Z5");
    // base FFFF0000, then an odd-length data record whose second write wraps past 2^32,
    // lower case decodes as zero, trailing byte dropped
    send_string(":02FFFE04FFFFFC");
    send_string(":05FFFE00A1b2C3D4E5F6");
    // record cut short by a new colon, then base back to zero
    send_string(":04123400AB");
    send_string(":020000040000FA");

    while (chars_sent < RANDOM_CHARS) begin
      pick = $urandom_range(0, 99);
      if (!held && chars_sent >= 600) begin
        held = 1'b1;
        hold_off_req <= 1'b1;
      end
      if (!drained && chars_sent >= 1200) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        wait_for_writes();
      end
      if (!long_done && chars_sent >= 900) begin
        // runs the position counter into saturation
        long_done = 1'b1;
        len = ($urandom_range(0, 1) == 1) ? 255 : $urandom_range(128, 254);
        send_record(8'(len), 16'($urandom), REC_TYPE_DATA, 1040, 1'b0);
      end else if (pick < 55) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
        n_payload = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2 * len) : 2 * len;
        send_record(8'(len), 16'($urandom), REC_TYPE_DATA, n_payload, 1'b0);
      end else if (pick < 68) begin
        send_record(8'd2, 16'($urandom), REC_TYPE_ELA, 4, $urandom_range(0, 5) == 0);
      end else if (pick < 78) begin
        type_char = ($urandom_range(0, 1) == 1) ? hex_digit(4'($urandom_range(1, 15)))
                                                : 8'($urandom);
        send_record(8'($urandom_range(0, 16)), 16'($urandom), type_char,
                    $urandom_range(0, 24), 1'b0);
      end else if (pick < 90) begin
        len = $urandom_range(0, 16);
        send_record(8'(len), 16'($urandom), REC_TYPE_DATA, 2 * len, 1'b1);
      end else begin
        repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
      end
    end

    in_valid <= 1'b0;
    wait_for_writes();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** hex_record_flash_writer: PASSED **");
    end else begin
      $display("** hex_record_flash_writer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hrfw_pkg.sv
rtl/hrfw_front.sv
rtl/hrfw_queue.sv
rtl/hrfw_back.sv
rtl/hex_record_flash_writer.sv
verif/hex_record_flash_writer_checker.sv
verif/hex_record_flash_writer_tb.sv
